// ----- hw/rtl/fault_code_debounce_table_core_assert.svh -----
// assertion macros for the fault code debounce table
`ifndef FAULT_CODE_DEBOUNCE_TABLE_CORE_ASSERT_SVH
`define FAULT_CODE_DEBOUNCE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FCDT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fcdt assertion failed");

// next-cycle implication, checked out of reset
`define FCDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fcdt assertion failed");

`endif

// ----- hw/rtl/fcdt_pkg.sv -----
`default_nettype none
package fcdt_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned COUNT_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_REPORT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END_PASS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic               exec;
        logic [FUNC_W-1:0]  func;
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] threshold;
    } cmd_t;

    // per-cell status back to the top
    typedef struct packed {
        logic hit;
        logic latch;
    } cell_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fcdt_cell.sv -----
`default_nettype none
module fcdt_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fcdt_pkg::cmd_t     cmd,
    input  wire logic               any_hit,
    input  wire logic               nofree_in,
    output logic                    nofree_out,
    output fcdt_pkg::cell_stat_t    stat
);

    logic [fcdt_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [fcdt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         seen_reg, seen_next;
    logic                         valid_reg, valid_next;

    logic                         hit;
    logic                         claim;
    logic [fcdt_pkg::COUNT_W-1:0] cnt_up;
    logic [fcdt_pkg::COUNT_W-1:0] cnt_dn;

    assign hit        = valid_reg && (code_reg == cmd.code);
    assign cnt_up     = (count_reg < cmd.threshold) ? count_reg + 8'd1 : count_reg;
    assign cnt_dn     = (count_reg != 8'd0) ? count_reg - 8'd1 : 8'd0;
    // first free entry: every cell below is occupied
    assign claim      = nofree_in && !valid_reg;
    assign nofree_out = nofree_in && valid_reg;
    assign stat.hit   = hit;
    assign stat.latch = (cnt_up >= cmd.threshold);

    always_comb begin
        code_next  = code_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        valid_next = valid_reg;
        if (cmd.exec) begin
            unique case (cmd.func)
                fcdt_pkg::FUNC_REPORT: begin
                    if (hit) begin
                        seen_next  = 1'b1;
                        count_next = cnt_up;
                    end else if (claim && !any_hit) begin
                        valid_next = 1'b1;
                        code_next  = cmd.code;
                        count_next = 8'd1;
                        seen_next  = 1'b1;
                    end
                end
                fcdt_pkg::FUNC_END_PASS: begin
                    if (valid_reg && !seen_reg) begin
                        count_next = cnt_dn;
                        if (cnt_dn == 8'd0) begin
                            valid_next = 1'b0;
                        end
                    end
                    seen_next = 1'b0;
                end
                fcdt_pkg::FUNC_CLEAR: begin
                    valid_next = 1'b0;
                    count_next = 8'd0;
                    seen_next  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/fault_code_debounce_table_core.sv -----
`default_nettype none
// Leaky-bucket fault debounce table. A report transaction (func 0) looks its
// fault code up in a row of TABLE_ENTRIES cells; a hit counts up toward
// count_threshold, a miss claims the lowest free cell with count 1, and one
// result (latch_now, table_full) is returned. End of pass (func 1) leaks one
// count from every unseen entry and frees entries at zero; clear (func 2)
// empties the table; neither returns a result, and func 3 is ignored. Each
// transaction is first registered, then the cells compare, resolve the
// first-free chain and update; a report waits until the result register is
// free or being drained. No new transaction is accepted until the held one
// executes. The user must write count_threshold through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce it. It resets to 3.
module fault_code_debounce_table_core #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // command channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_fault_code,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_latch_now,
    output logic             m_table_full
);

`include "fault_code_debounce_table_core_assert.svh"

    // threshold register
    logic [fcdt_pkg::COUNT_W-1:0] count_threshold_reg;

    // command holding stage
    logic                         cmd_valid_reg, cmd_valid_next;
    logic [fcdt_pkg::FUNC_W-1:0]  cmd_func_reg;
    logic [fcdt_pkg::CODE_W-1:0]  cmd_code_reg;

    // result register
    logic                         m_valid_reg, m_valid_next;
    logic                         m_latch_reg;
    logic                         m_full_reg;

    logic                         exec;
    logic                         is_report;
    fcdt_pkg::cmd_t               cmd;

    // cell chain
    logic [TABLE_ENTRIES:0]       nofree;
    fcdt_pkg::cell_stat_t         stat [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]     hit_vec;
    logic [TABLE_ENTRIES-1:0]     latch_vec;
    logic                         any_hit;
    logic                         table_full;
    logic                         res_latch;

    // config write, no handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_threshold_reg <= fcdt_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            count_threshold_reg <= cfg_wdata;
        end
    end

    // input stage holds one transaction at a time
    assign s_ready   = !cmd_valid_reg;
    assign is_report = (cmd_func_reg == fcdt_pkg::FUNC_REPORT);
    // reports wait for room in the result register, others go at once
    assign exec      = cmd_valid_reg && (!is_report || !m_valid_reg || m_ready);

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (exec) begin
            cmd_valid_next = 1'b0;
        end else if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_func_reg <= s_func;
            cmd_code_reg <= s_fault_code;
        end
    end

    // broadcast command to the cells
    assign cmd.exec      = exec;
    assign cmd.func      = cmd_func_reg;
    assign cmd.code      = cmd_code_reg;
    assign cmd.threshold = count_threshold_reg;

    // first-free search ripples up the chain from cell 0
    assign nofree[0] = 1'b1;

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        fcdt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .any_hit    (any_hit),
            .nofree_in  (nofree[gi]),
            .nofree_out (nofree[gi+1]),
            .stat       (stat[gi])
        );
        assign hit_vec[gi]   = stat[gi].hit;
        assign latch_vec[gi] = stat[gi].latch;
    end

    // codes are unique among valid entries, so at most one cell hits
    assign any_hit    = |hit_vec;
    assign table_full = !any_hit && nofree[TABLE_ENTRIES];

    always_comb begin
        priority if (any_hit) begin
            res_latch = |(hit_vec & latch_vec);
        end else if (table_full) begin
            res_latch = 1'b1;
        end else begin
            // new entry starts at count one
            res_latch = (count_threshold_reg <= 8'd1);
        end
    end

    // result register parts the two channels
    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec && is_report) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && is_report) begin
            m_latch_reg <= res_latch;
            m_full_reg  <= table_full;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_latch_now  = m_latch_reg;
    assign m_table_full = m_full_reg;

    // no two cells ever hold the same code
    `FCDT_ASSERT_NOW(a_single_hit, aclk, aresetn, cmd_valid_reg, $onehot0(hit_vec))
    // an executed report always produces a result
    `FCDT_ASSERT_NEXT(a_report_result, aclk, aresetn, exec && is_report, m_valid_reg)
    // a full table always latches
    `FCDT_ASSERT_NOW(a_full_latches, aclk, aresetn, m_valid_reg && m_full_reg, m_latch_reg)
    // a held report never executes over an undrained result
    `FCDT_ASSERT_NOW(a_no_overrun, aclk, aresetn, exec && is_report && m_valid_reg, m_ready)

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;

    localparam int unsigned FUNC_W  = fcdt_pkg::FUNC_W;
    localparam int unsigned CODE_W  = fcdt_pkg::CODE_W;
    localparam int unsigned COUNT_W = fcdt_pkg::COUNT_W;

    localparam int unsigned NUM_ENTRIES    = 8;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          POOL_SIZE      = 10;

    // func value the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // one expected answer to a report transaction
    typedef struct packed {
        logic latch_now;
        logic table_full;
    } verdict_t;

    // clock, reset and block ports
    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [7:0]         cfg_wdata    = 8'd0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [FUNC_W-1:0]  s_func       = fcdt_pkg::FUNC_REPORT;
    logic [CODE_W-1:0]  s_fault_code = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_latch_now;
    logic               m_table_full;

    // shadow copy of the fault table and the threshold register
    logic [CODE_W-1:0]  tbl_code  [NUM_ENTRIES];
    logic [COUNT_W-1:0] tbl_count [NUM_ENTRIES];
    bit                 tbl_seen  [NUM_ENTRIES];
    bit                 tbl_valid [NUM_ENTRIES];
    logic [COUNT_W-1:0] threshold_model;

    verdict_t pending_verdicts[$];
    int       err_count    = 0;
    int       idle_cycles  = 0;
    int       send_gap_max = 18;
    int       recv_gap_max = 18;
    bit       hold_req     = 1'b0;

    fault_code_debounce_table_core #(
        .TABLE_ENTRIES(NUM_ENTRIES)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_fault_code (s_fault_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_latch_now  (m_latch_now),
        .m_table_full (m_table_full)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------
    function automatic void empty_table();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            tbl_code[i]  = '0;
            tbl_count[i] = '0;
            tbl_seen[i]  = 1'b0;
            tbl_valid[i] = 1'b0;
        end
    endfunction

    // applies one transaction to the shadow table; returns 1 when a result is due
    function automatic bit debounce_step(input logic [FUNC_W-1:0] func,
                                         input logic [CODE_W-1:0] code,
                                         output verdict_t v);
        int slot;
        slot = -1;
        v    = '0;
        case (func)
            fcdt_pkg::FUNC_REPORT: begin
                // a hit marks the entry seen and counts up, saturating at threshold
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_code[i] == code) begin
                        tbl_seen[i] = 1'b1;
                        if (tbl_count[i] < threshold_model)
                            tbl_count[i] = tbl_count[i] + 1'b1;
                        v.latch_now = (tbl_count[i] >= threshold_model);
                        return 1'b1;
                    end
                end
                // miss: lowest free entry, or table full
                for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
                    if (!tbl_valid[i])
                        slot = i;
                end
                if (slot < 0) begin
                    v.latch_now  = 1'b1;
                    v.table_full = 1'b1;
                    return 1'b1;
                end
                tbl_valid[slot] = 1'b1;
                tbl_code[slot]  = code;
                tbl_count[slot] = 8'd1;
                tbl_seen[slot]  = 1'b1;
                v.latch_now     = (tbl_count[slot] >= threshold_model);
                return 1'b1;
            end
            fcdt_pkg::FUNC_END_PASS: begin
                // leak unseen entries, free at zero, then clear seen marks
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (tbl_valid[i] && !tbl_seen[i]) begin
                        if (tbl_count[i] > 0)
                            tbl_count[i] = tbl_count[i] - 1'b1;
                        if (tbl_count[i] == 0)
                            tbl_valid[i] = 1'b0;
                    end
                    tbl_seen[i] = 1'b0;
                end
                return 1'b0;
            end
            fcdt_pkg::FUNC_CLEAR: begin
                empty_table();
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // offers one transaction after a random gap and predicts it once accepted
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CODE_W-1:0] code);
        int       gap;
        verdict_t v;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_fault_code <= code;
        do @(posedge aclk); while (!s_ready);
        if (debounce_step(func, code, v))
            pending_verdicts.push_back(v);
    endtask

    task automatic send_report(input logic [CODE_W-1:0] code);
        send_item(fcdt_pkg::FUNC_REPORT, code);
    endtask

    // drop valid, drain all results, then let a transaction with no result finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we          <= 1'b0;
        threshold_model = value;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset threshold: counting, saturation, code extremes, full table, leak, clear
    task automatic test_table_basics();
        send_report(16'h0000);              // code zero behaves like any code
        repeat (3) send_report(16'hFFFF);   // latches on the third report
        send_report(16'hFFFF);              // saturated at threshold
        send_item(FUNC_UNUSED, 16'hFFFF);   // ignored, no result
        send_report(16'hA5A5);
        send_report(16'h5A5A);
        send_report(16'h0001);
        send_report(16'h8000);
        send_report(16'h7FFF);
        send_report(16'h1234);              // all eight entries now taken
        send_report(16'hBEEF);              // no room
        send_item(fcdt_pkg::FUNC_END_PASS, 16'h0000); // everything seen, only marks clear
        send_item(fcdt_pkg::FUNC_END_PASS, 16'hFFFF); // leak: count-one entries freed
        send_report(16'hBEEF);              // claims the lowest freed entry
        send_report(16'hFFFF);              // leaked entry counts back up
        send_item(fcdt_pkg::FUNC_CLEAR, 16'h5555);
        send_report(16'hFFFF);              // new again after clear
        wait_idle();
    endtask

    // threshold extremes and a threshold lowered below a stored count
    task automatic test_threshold_edges();
        write_threshold(8'd1);
        send_report(16'h0042);              // first report latches
        wait_idle();
        write_threshold(8'd255);
        send_report(16'h0042);
        send_report(16'h0043);
        wait_idle();
        write_threshold(8'd0);              // zero: always latched, no counting
        send_report(16'h0044);
        send_report(16'h0042);
        wait_idle();
        write_threshold(8'd5);
        send_item(fcdt_pkg::FUNC_CLEAR, 16'h0000);
        repeat (4) send_report(16'h0077);
        wait_idle();
        write_threshold(8'd2);              // below the stored count of four
        send_report(16'h0077);
        wait_idle();
    endtask

    // mostly reports from a small code pool so hits, leaks and overflow all happen
    task automatic run_random_phase(input logic [7:0] thr, input int n_items);
        logic [CODE_W-1:0] pool [POOL_SIZE];
        int                r;
        logic [CODE_W-1:0] code;
        wait_idle();
        write_threshold(thr);
        foreach (pool[i])
            pool[i] = CODE_W'($urandom_range(16'hFFFF, 0));
        for (int k = 0; k < n_items; k++) begin
            r    = $urandom_range(99, 0);
            code = CODE_W'($urandom_range(16'hFFFF, 0));
            if (r < 70)
                send_report(pool[$urandom_range(POOL_SIZE - 1, 0)]);
            else if (r < 78)
                send_report(code);
            else if (r < 92)
                send_item(fcdt_pkg::FUNC_END_PASS, code);
            else if (r < 96)
                send_item(fcdt_pkg::FUNC_CLEAR, code);
            else
                send_item(FUNC_UNUSED, code);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(8'd1, 70);
        run_random_phase(8'd2, 70);
        run_random_phase(fcdt_pkg::THRESHOLD_RESET, 70);
        run_random_phase(8'd255, 50);
        run_random_phase(8'($urandom_range(255, 0)), 70);
        // back-to-back stretch with no idling on either side
        send_gap_max = 0;
        recv_gap_max = 0;
        run_random_phase(8'd4, 70);
        send_gap_max = 18;
        recv_gap_max = 18;
        wait_idle();
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_result_backpressure();
        write_threshold(8'd3);
        send_item(fcdt_pkg::FUNC_CLEAR, 16'h0000);
        wait_idle();
        send_gap_max = 0;
        hold_req     = 1'b1;
        for (int k = 0; k < 24; k++)
            send_report(CODE_W'($urandom_range(7, 0) * 16'h1111));
        send_gap_max = 18;
        // sender pauses until every result is back
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // result receiver: random ready gaps plus the long hold-off
    // ------------------------------------------------------------------
    initial begin
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            n = $urandom_range(recv_gap_max, 0);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && !hold_req);
        end
    end

    // ------------------------------------------------------------------
    // result checker: in-order compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result, latch_now", m_latch_now, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_latch_now !== want.latch_now)
                    report_mismatch("latch_now", m_latch_now, want.latch_now);
                if (m_table_full !== want.table_full)
                    report_mismatch("table_full", m_table_full, want.table_full);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("fault_code_debounce_table_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        threshold_model = fcdt_pkg::THRESHOLD_RESET;
        empty_table();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_basics();
        test_threshold_edges();
        test_random_traffic();
        test_result_backpressure();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (err_count == 0 && pending_verdicts.size() == 0)
            $display("fault_code_debounce_table_core: match");
        else
            $display("fault_code_debounce_table_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// ----- fault_code_debounce_table_core.f -----
+incdir+hw/rtl
hw/rtl/fcdt_pkg.sv
hw/rtl/fcdt_cell.sv
hw/rtl/fault_code_debounce_table_core.sv
tb/sv/testbench.sv
